>>> rtl/lohc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lohc_pkg: shared types and constants of the loose object header check
// Status codes, type names, verdict record and field widths.
// ---------------------------------------------------------------------------
package lohc_pkg;

   localparam int LEN_W                = 31;
   localparam int ACC_W                = 64;
   localparam int OFFSET_W             = 6;
   localparam int HEADER_LIMIT_DEFAULT = 32;

   localparam logic [LEN_W-1:0] LEN_MAX       = {LEN_W{1'b1}};
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd1073741824;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_NUL    = 3'd1,
      ST_BAD_TYPE  = 3'd2,
      ST_BAD_DIGIT = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_MISMATCH  = 3'd5,
      ST_TOO_LONG  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OBJ_BLOB   = 2'd0,
      OBJ_TREE   = 2'd1,
      OBJ_COMMIT = 2'd2,
      OBJ_TAG    = 2'd3
   } obj_type;

   // one byte of the object as held in the input register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } byte_item_type;

   // verdict for one object, handed to the result register
   typedef struct packed {
      status_type       status;
      obj_type          kind;
      logic [LEN_W-1:0] size;
      logic [OFFSET_W-1:0] offset;
   } verdict_type;

   // length of each type name
   function automatic logic [2:0] type_len(input logic [1:0] k);
      logic [2:0] len;
      unique case (obj_type'(k))
         OBJ_BLOB:   len = 3'd4;
         OBJ_TREE:   len = 3'd4;
         OBJ_COMMIT: len = 3'd6;
         OBJ_TAG:    len = 3'd3;
         default:    len = 3'd0;
      endcase
      return len;
   endfunction

   // character of a type name at a given position
   function automatic logic [7:0] type_char(input logic [1:0] k, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      unique case (obj_type'(k))
         OBJ_BLOB: begin
            unique case (idx)
               3'd0:    c = "b";
               3'd1:    c = "l";
               3'd2:    c = "o";
               3'd3:    c = "b";
               default: c = 8'h00;
            endcase
         end
         OBJ_TREE: begin
            unique case (idx)
               3'd0:    c = "t";
               3'd1:    c = "r";
               3'd2:    c = "e";
               3'd3:    c = "e";
               default: c = 8'h00;
            endcase
         end
         OBJ_COMMIT: begin
            unique case (idx)
               3'd0:    c = "c";
               3'd1:    c = "o";
               3'd2:    c = "m";
               3'd3:    c = "m";
               3'd4:    c = "i";
               3'd5:    c = "t";
               default: c = 8'h00;
            endcase
         end
         OBJ_TAG: begin
            unique case (idx)
               3'd0:    c = "t";
               3'd1:    c = "a";
               3'd2:    c = "g";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/lohc_in_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lohc_in_reg: input register of the header check
// Takes one byte transfer a cycle while not stalled and holds it until the scan stage uses it.
// ---------------------------------------------------------------------------
module lohc_in_reg
   import lohc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last,
   input  logic          advance,
   output logic          item_valid,
   output byte_item_type item
);

   logic          valid_ff;
   logic          valid_in;
   byte_item_type item_ff;
   logic          take;

   // stall only while a held byte cannot move on
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture payload on each transfer
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte <= req_data_byte;
         item_ff.last      <= req_last;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/lohc_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lohc_scan: per-object header scan
// Tracks type candidates, decimal size, counts and the first digit error,
// and forms the verdict for the byte that closes the object.
// ---------------------------------------------------------------------------
module lohc_scan
   import lohc_pkg::*;
#(
   parameter int HEADER_LIMIT = HEADER_LIMIT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  byte_item_type    item,
   input  logic [LEN_W-1:0] max_len,
   output verdict_type      verdict
);

   localparam int POS_W = $clog2(HEADER_LIMIT + 2);

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic             in_body_ff, in_body_in;
   logic [3:0]       cand_ff,  cand_in;
   logic [ACC_W-1:0] acc_ff,   acc_in;
   status_type       ferr_ff,  ferr_in;
   logic [LEN_W-1:0] body_ff,  body_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic             ovf_ff,   ovf_in;

   logic             digit_hit;
   logic [3:0]       dval;
   logic [ACC_W+3:0] prod;
   logic             type_ok;
   obj_type          kind;
   status_type       status;
   logic [6:0]       off7;

   // advance the per-byte state
   always_comb begin
      pos_in     = pos_ff;
      in_body_in = in_body_ff;
      cand_in    = cand_ff;
      acc_in     = acc_ff;
      ferr_in    = ferr_ff;
      body_in    = body_ff;
      total_in   = total_ff;
      ovf_in     = ovf_ff;
      digit_hit  = 1'b0;
      dval       = 4'd0;
      prod       = '0;

      if (total_ff == LEN_MAX) begin
         ovf_in = 1'b1;
      end else begin
         total_in = total_ff + 1'b1;
      end

      if (in_body_ff) begin
         if (body_ff != LEN_MAX) begin
            body_in = body_ff + 1'b1;
         end
      end else if (pos_ff <= POS_W'(HEADER_LIMIT)) begin
         if (item.data_byte == CHAR_NUL) begin
            in_body_in = 1'b1;
         end else begin
            for (int k = 0; k < 4; k++) begin
               if (cand_ff[k]) begin
                  if (pos_ff < POS_W'(type_len(2'(k)))) begin
                     if (item.data_byte != type_char(2'(k), pos_ff[2:0])) begin
                        cand_in[k] = 1'b0;
                     end
                  end else if (pos_ff == POS_W'(type_len(2'(k)))) begin
                     if (item.data_byte != CHAR_SPACE) begin
                        cand_in[k] = 1'b0;
                     end
                  end else begin
                     digit_hit = 1'b1;
                  end
               end
            end
            pos_in = pos_ff + 1'b1;

            // accumulate a size digit: acc * 10 + d, flag 64-bit overflow
            if (digit_hit && ferr_ff == ST_OK) begin
               if (item.data_byte < CHAR_0 || item.data_byte > CHAR_9) begin
                  ferr_in = ST_BAD_DIGIT;
               end else begin
                  dval = item.data_byte[3:0];
                  prod = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                       + (ACC_W+4)'(dval);
                  if (prod[ACC_W+3:ACC_W] != 4'd0) begin
                     ferr_in = ST_OVERFLOW;
                  end else begin
                     acc_in = prod[ACC_W-1:0];
                  end
               end
            end
         end
      end
   end

   // pick the matching type; a closing NUL leaves position and candidates as held
   always_comb begin
      type_ok = 1'b0;
      kind    = OBJ_BLOB;
      for (int k = 3; k >= 0; k--) begin
         if (cand_ff[k] && int'(pos_ff) > int'(type_len(2'(k))) + 1) begin
            type_ok = 1'b1;
            kind    = obj_type'(2'(k));
         end
      end
   end

   // rank the errors
   always_comb begin
      priority if (ovf_in || total_in > max_len) begin
         status = ST_TOO_LONG;
      end else if (!in_body_in) begin
         status = ST_NO_NUL;
      end else if (!type_ok) begin
         status = ST_BAD_TYPE;
      end else if (ferr_ff != ST_OK) begin
         status = ferr_ff;
      end else if (acc_ff != ACC_W'(body_in)) begin
         status = ST_MISMATCH;
      end else begin
         status = ST_OK;
      end
   end

   // fill the verdict; detail fields only for ok and mismatch
   always_comb begin
      off7           = 7'(pos_ff) + 7'd1;
      verdict.status = status;
      verdict.kind   = OBJ_BLOB;
      verdict.size   = '0;
      verdict.offset = '0;
      if (status == ST_OK || status == ST_MISMATCH) begin
         verdict.kind   = kind;
         verdict.size   = (acc_ff > ACC_W'(LEN_MAX)) ? LEN_MAX : acc_ff[LEN_W-1:0];
         verdict.offset = off7[OFFSET_W-1:0];
      end
   end

   // hold state; drop it after the closing byte
   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         pos_ff     <= '0;
         in_body_ff <= 1'b0;
         cand_ff    <= 4'b1111;
         acc_ff     <= '0;
         ferr_ff    <= ST_OK;
         body_ff    <= '0;
         total_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else if (step) begin
         pos_ff     <= pos_in;
         in_body_ff <= in_body_in;
         cand_ff    <= cand_in;
         acc_ff     <= acc_in;
         ferr_ff    <= ferr_in;
         body_ff    <= body_in;
         total_ff   <= total_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

>>> rtl/lohc_out_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lohc_out_reg: result register of the header check
// Holds one verdict until the receiver takes the transfer.
// ---------------------------------------------------------------------------
module lohc_out_reg
   import lohc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  verdict_type         verdict,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [2:0]          rsp_status,
   output logic [1:0]          rsp_obj_kind,
   output logic [LEN_W-1:0]    rsp_declared_size,
   output logic [OFFSET_W-1:0] rsp_data_start
);

   logic        valid_ff;
   verdict_type verdict_ff;

   // free when empty or the held verdict leaves this cycle
   assign ready = !(valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_ok            = (verdict_ff.status == ST_OK);
   assign rsp_status        = verdict_ff.status;
   assign rsp_obj_kind      = verdict_ff.kind;
   assign rsp_declared_size = verdict_ff.size;
   assign rsp_data_start    = verdict_ff.offset;

endmodule

>>> rtl/loose_object_header_check_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// loose_object_header_check_top: header check of an inflated loose object
// Checks "<type> <decimal>\0", the size against the body and the length limit.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries the object one byte per transfer, req_last on
//   the final byte. Only the final byte produces a transfer on the rsp_
//   channel: ok, status, object type, declared size and body offset.
//   csr_wr_en with csr_wr_data sets the length limit; write it while idle.
// Timing:
//   One byte is taken every cycle while req_stall is low. A byte is held in
//   the input register and scanned from there; the last byte of an object
//   loads its verdict into the result register, which offers it. The per-byte
//   path is the type compare and the shift-add of the 64-bit size value.
// Reset:
//   Synchronous, active high; clears the scan state, empties both registers
//   and sets the length limit to 1073741824.
// Stall:
//   While rsp_stall holds a verdict, further body and header bytes still
//   flow; a final byte waits in the input register and req_stall rises.
// ---------------------------------------------------------------------------
module loose_object_header_check_top
   import lohc_pkg::*;
#(
   parameter int HEADER_LIMIT = HEADER_LIMIT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [2:0]          rsp_status,
   output logic [1:0]          rsp_obj_kind,
   output logic [LEN_W-1:0]    rsp_declared_size,
   output logic [OFFSET_W-1:0] rsp_data_start,
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data
);

   logic [LEN_W-1:0] limit_ff;
   logic             item_valid;
   byte_item_type    item;
   logic             advance;
   logic             out_ready;
   verdict_type      verdict;

   // length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // a closing byte moves on only when the result register is free
   assign advance = item_valid && (!item.last || out_ready);

   lohc_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   lohc_scan #(
      .HEADER_LIMIT (HEADER_LIMIT)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (item),
      .max_len (limit_ff),
      .verdict (verdict)
   );

   lohc_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && item.last),
      .verdict           (verdict),
      .ready             (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_status        (rsp_status),
      .rsp_obj_kind      (rsp_obj_kind),
      .rsp_declared_size (rsp_declared_size),
      .rsp_data_start    (rsp_data_start)
   );

   // a blocked closing byte means a verdict is waiting at the output
   a_blocked_last: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.last && !advance) |-> (rsp_valid && rsp_stall))
      else $error("closing byte blocked without a waiting verdict");

   // every closing byte that moves on yields a verdict next cycle
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      (advance && item.last) |=> rsp_valid)
      else $error("verdict missing after closing byte");

   // detail fields are zero unless ok or size mismatch
   a_detail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK && rsp_status != ST_MISMATCH) |->
      (rsp_obj_kind == 2'd0 && rsp_declared_size == '0 && rsp_data_start == '0))
      else $error("detail fields set for an error verdict");

   // the shortest good header is "tag 0" so the body starts at six or later
   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_data_start >= OFFSET_W'(6)))
      else $error("ok verdict with a short header");

endmodule

>>> test/loose_object_header_check_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// loose_object_header_check_top_test: self-checking bench for the header check
// Streams whole objects byte by byte through the request channel, predicts
// the verdict of each object from a local scan of the header, and compares
// every verdict transfer field by field. Runs a directed set of headers, then
// random objects under several length limits and idling patterns, including
// one long hold-off on the verdict side.
// ---------------------------------------------------------------------------
module loose_object_header_check_top_test
   import lohc_pkg::*;
();

   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 11;
   localparam int SCAN_LIMIT      = HEADER_LIMIT_DEFAULT;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RUN_LIMIT_NS    = 2000000;

   // one expected verdict per object
   typedef struct packed {
      logic                ok;
      status_type          status;
      obj_type             kind;
      logic [LEN_W-1:0]    size;
      logic [OFFSET_W-1:0] offset;
   } object_verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_ok;
   logic [2:0]          rsp_status;
   logic [1:0]          rsp_obj_kind;
   logic [LEN_W-1:0]    rsp_declared_size;
   logic [OFFSET_W-1:0] rsp_data_start;
   logic                csr_wr_en = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data = '0;

   // scan state of the object in progress
   logic [5:0]          hdr_pos;
   bit                  past_nul;
   logic [3:0]          kinds_alive;
   logic [63:0]         size_acc;
   status_type          digit_err;
   logic [LEN_W-1:0]    body_len;
   logic [LEN_W-1:0]    obj_len;
   bit                  len_wrap;
   logic [LEN_W-1:0]    limit_bytes = MAX_LEN_RESET;

   byte_item_type       object_bytes[$];
   object_verdict_type  pending_verdicts[$];
   logic [7:0]          draft[$];
   object_verdict_type  fresh_verdict;
   object_verdict_type  due;
   byte_item_type       next_item;
   int unsigned         bytes_queued = 0;
   int unsigned         bytes_taken = 0;
   int unsigned         fail_count = 0;
   int unsigned         send_gap_pct = 0;
   int unsigned         hold_pct = 0;
   bit                  pressure_on = 1'b0;
   bit                  pressure_done = 1'b0;
   int unsigned         hold_left = 0;

   loose_object_header_check_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_status        (rsp_status),
      .rsp_obj_kind      (rsp_obj_kind),
      .rsp_declared_size (rsp_declared_size),
      .rsp_data_start    (rsp_data_start),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic string kind_name(input obj_type k);
      unique case (k)
         OBJ_BLOB:   return "blob";
         OBJ_TREE:   return "tree";
         OBJ_COMMIT: return "commit";
         default:    return "tag";
      endcase
   endfunction

   function automatic void clear_scan();
      hdr_pos     = '0;
      past_nul    = 1'b0;
      kinds_alive = 4'hF;
      size_acc    = '0;
      digit_err   = ST_OK;
      body_len    = '0;
      obj_len     = '0;
      len_wrap    = 1'b0;
   endfunction

   // accumulate one size digit; keep only the first error
   function automatic void take_digit(input logic [7:0] b);
      logic [63:0] d;
      if (digit_err != ST_OK) return;
      if (b < CHAR_0 || b > CHAR_9) begin
         digit_err = ST_BAD_DIGIT;
         return;
      end
      d = 64'(b - CHAR_0);
      if (size_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
         digit_err = ST_OVERFLOW;
         return;
      end
      size_acc = size_acc * 64'd10 + d;
   endfunction

   // match the byte against every type name still alive
   function automatic void take_header(input logic [7:0] b);
      string nm;
      if (b == CHAR_NUL) begin
         past_nul = 1'b1;
         return;
      end
      for (int k = 0; k < 4; k++) begin
         nm = kind_name(obj_type'(k));
         if (kinds_alive[k]) begin
            if (hdr_pos < nm.len()) begin
               if (b != nm[hdr_pos]) kinds_alive[k] = 1'b0;
            end else if (hdr_pos == nm.len()) begin
               if (b != CHAR_SPACE) kinds_alive[k] = 1'b0;
            end else begin
               take_digit(b);
            end
         end
      end
      hdr_pos = hdr_pos + 6'd1;
   endfunction

   // advance the scan by one byte; on the final byte give the verdict
   function automatic bit scan_byte(input logic [7:0] b, input logic fin,
                                    output object_verdict_type v);
      bit         typed;
      obj_type    found;
      status_type st;
      string      nm;
      typed = 1'b0;
      found = OBJ_BLOB;
      v     = '0;
      if (obj_len == LEN_MAX) len_wrap = 1'b1;
      else obj_len = obj_len + 1'b1;
      if (past_nul) begin
         if (body_len < LEN_MAX) body_len = body_len + 1'b1;
      end else if (hdr_pos <= SCAN_LIMIT) begin
         take_header(b);
      end
      if (!fin) return 1'b0;
      // the first surviving type with at least one digit wins
      if (past_nul) begin
         for (int k = 0; k < 4; k++) begin
            nm = kind_name(obj_type'(k));
            if (!typed && kinds_alive[k] && hdr_pos > nm.len() + 1) begin
               typed = 1'b1;
               found = obj_type'(k);
            end
         end
      end
      if (len_wrap || obj_len > limit_bytes) st = ST_TOO_LONG;
      else if (!past_nul) st = ST_NO_NUL;
      else if (!typed) st = ST_BAD_TYPE;
      else if (digit_err != ST_OK) st = digit_err;
      else if (size_acc != 64'(body_len)) st = ST_MISMATCH;
      else st = ST_OK;
      v.ok     = (st == ST_OK);
      v.status = st;
      if (st == ST_OK || st == ST_MISMATCH) begin
         v.kind   = found;
         v.size   = (size_acc > 64'(LEN_MAX)) ? LEN_MAX : size_acc[LEN_W-1:0];
         v.offset = hdr_pos + 6'd1;
      end
      clear_scan();
      return 1'b1;
   endfunction

   // object building: collect bytes in the draft, then queue them with last set on the final byte
   function automatic void draft_text(input string s);
      for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
   endfunction

   function automatic void draft_header(input string s);
      draft_text(s);
      draft.push_back(CHAR_NUL);
   endfunction

   function automatic void draft_body(input int unsigned n);
      repeat (n) draft.push_back(8'($urandom_range(255)));
   endfunction

   function automatic string zeros(input int unsigned n);
      string s;
      s = "";
      repeat (n) s = {s, "0"};
      return s;
   endfunction

   function automatic void ship_draft();
      byte_item_type item;
      foreach (draft[i]) begin
         item.data_byte = draft[i];
         item.last      = (i == draft.size() - 1);
         object_bytes.push_back(item);
      end
      bytes_queued += draft.size();
      draft.delete();
   endfunction

   // mostly well-formed objects, the rest noise and damaged headers
   function automatic void draft_random_object();
      int unsigned pick;
      int unsigned body_bytes;
      int unsigned digit_at;
      logic [63:0] declared;
      logic [7:0]  b;
      string       digits;
      pick       = $urandom_range(99);
      body_bytes = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(10);
      if (pick < 10) begin
         repeat ($urandom_range(1, 40)) begin
            b = 8'($urandom_range(255));
            if ($urandom_range(5) == 0) b = CHAR_NUL;
            draft.push_back(b);
         end
         return;
      end
      declared = 64'(body_bytes);
      if (pick < 16) declared = declared ^ 64'($urandom_range(1, 3));
      else if (pick < 20) declared = {$urandom, $urandom} >> $urandom_range(63);
      digits = $sformatf("%0d", declared);
      if (pick >= 20 && pick < 25) begin
         // more digits than 64 bits can hold
         digits = $sformatf("%0d", $urandom_range(1, 9));
         repeat ($urandom_range(20, 24)) digits = {digits, $sformatf("%0d", $urandom_range(9))};
      end
      if ($urandom_range(9) == 0) digits = {zeros($urandom_range(1, 10)), digits};
      draft_text(kind_name(obj_type'($urandom_range(3))));
      b = CHAR_SPACE;
      if (pick >= 25 && pick < 28) b = 8'($urandom_range(255));
      draft.push_back(b);
      digit_at = draft.size();
      if (!(pick >= 28 && pick < 30)) draft_text(digits);
      if (pick >= 30 && pick < 34 && draft.size() > digit_at) begin
         b = ($urandom_range(1) == 0) ? 8'($urandom_range(1, 47)) : 8'($urandom_range(58, 255));
         draft[$urandom_range(digit_at, draft.size() - 1)] = b;
      end
      if (!(pick >= 34 && pick < 37)) draft.push_back(CHAR_NUL);
      if (pick >= 37 && pick < 41) draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
      draft_body(body_bytes);
   endfunction

   task automatic queue_random(input int unsigned n);
      int unsigned stop_at;
      stop_at = bytes_queued + n;
      while (bytes_queued < stop_at) begin
         draft_random_object();
         ship_draft();
      end
   endtask

   // wait until every byte is taken and every verdict has come back
   task automatic drain();
      while (!(bytes_taken == bytes_queued && pending_verdicts.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LEN_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_bytes = v;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s differs, expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // sender: predict on each transfer, then offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            bytes_taken++;
            if (scan_byte(req_data_byte, req_last, fresh_verdict))
               pending_verdicts.push_back(fresh_verdict);
         end
         if (object_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            next_item = object_bytes.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_item.data_byte;
            req_last      <= next_item.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, plus one long hold-off when asked
   always @(posedge clock) begin
      if (pressure_on && !pressure_done && rsp_valid) begin
         pressure_done <= 1'b1;
         hold_left     <= HOLD_OFF_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < hold_pct);
      end
   end

   // verdict check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: verdict with none expected, expected nothing, actual status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            due = pending_verdicts.pop_front();
            check_field("ok", 64'(due.ok), 64'(rsp_ok));
            check_field("status", 64'(due.status), 64'(rsp_status));
            check_field("kind", 64'(due.kind), 64'(rsp_obj_kind));
            check_field("declared_size", 64'(due.size), 64'(rsp_declared_size));
            check_field("data_start", 64'(due.offset), 64'(rsp_data_start));
         end
      end
   end

   initial begin
      clear_scan();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed headers under the reset limit
      send_gap_pct = 33;
      hold_pct     = 74;
      draft_header("blob 0");
      ship_draft();
      draft_header("tree 3");
      draft_body(3);
      ship_draft();
      draft_header("commit 12");
      draft_body(12);
      ship_draft();
      draft_header("tag 2");
      draft.push_back(8'hFF);
      draft.push_back(CHAR_NUL);
      ship_draft();
      // NUL on the last header position allowed, then one past it
      draft_header({"blob ", zeros(26), "1"});
      draft_body(1);
      ship_draft();
      draft_header({"tree ", zeros(28)});
      draft_body(2);
      ship_draft();
      // size mismatch, small and saturating
      draft_header("blob 5");
      draft_body(2);
      ship_draft();
      draft_header("commit 99999999999");
      draft_body(1);
      ship_draft();
      // size overflow, bad digit, bad digit ahead of overflow
      draft_header("tag 99999999999999999999999");
      ship_draft();
      draft_header("blob 1a");
      draft_body(1);
      ship_draft();
      draft_header("tree 7x99999999999999999999");
      ship_draft();
      // empty size, unknown type, missing space, lone NUL
      draft_header("blob ");
      ship_draft();
      draft_header("blub 1");
      draft_body(1);
      ship_draft();
      draft_header("blob1");
      draft_body(1);
      ship_draft();
      draft.push_back(CHAR_NUL);
      ship_draft();
      // no NUL at all, short and long
      draft_text("blob 1");
      ship_draft();
      repeat (40) draft.push_back(8'hFF);
      ship_draft();
      drain();

      // tightest limit
      set_limit(31'd6);
      queue_random(300);
      drain();

      // middle limit, idling swapped
      send_gap_pct = 74;
      hold_pct     = 33;
      set_limit(31'd45);
      queue_random(420);
      drain();

      // widest limit, no idling, one long hold-off
      send_gap_pct = 0;
      hold_pct     = 0;
      set_limit(MAX_LEN_RESET);
      pressure_on = 1'b1;
      queue_random(420);
      drain();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop
   initial begin
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
